/* hdl/aesc_pkg.sv */
// Shared types, character codes and helper functions of the expression syntax checker.
package aesc_pkg;

  // Character codes the automaton knows
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharOpen  = 8'h28;
  localparam logic [7:0] CharClose = 8'h29;
  localparam logic [7:0] CharMul   = 8'h2A;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharDiv   = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharEnd   = 8'h24;  // end-of-line mark in text form, for reference

  // Verdict codes on the result beat
  typedef enum logic [2:0] {
    V_PENDING    = 3'd0,
    V_SYNTAX     = 3'd1,
    V_FOREIGN    = 3'd2,
    V_ACCEPT     = 3'd3,
    V_INCOMPLETE = 3'd4,
    V_EMPTY      = 3'd5
  } verdict_e;

  // Latched first error of the line
  typedef enum logic [1:0] {
    F_NONE    = 2'd0,
    F_SYNTAX  = 2'd1,
    F_FOREIGN = 2'd2
  } fail_e;

  // Automaton states
  typedef enum logic [2:0] {
    S_START     = 3'd1,  // operand expected at top level
    S_NUM_TOP   = 3'd2,  // inside a top-level number
    S_OPND_PAR  = 3'd3,  // operand expected inside parentheses
    S_NUM_PAR   = 3'd4,  // inside a number inside parentheses
    S_CLOSE_IN  = 3'd5,  // after ')' with parentheses still open
    S_CLOSE_TOP = 3'd6   // after ')' that closed the last one
  } aut_state_e;

  // Character classes
  typedef enum logic [2:0] {
    C_NZDIGIT = 3'd0,
    C_ZERO    = 3'd1,
    C_OPEN    = 3'd2,
    C_CLOSE   = 3'd3,
    C_OP      = 3'd4,
    C_OTHER   = 3'd5
  } char_class_e;

  // One result beat
  typedef struct packed {
    verdict_e    verdict;
    logic [11:0] position;
    logic [7:0]  open_depth;
  } aesc_result_t;

  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e cls;
    if (c >= CharOne && c <= CharNine) cls = C_NZDIGIT;
    else if (c == CharZero) cls = C_ZERO;
    else if (c == CharOpen) cls = C_OPEN;
    else if (c == CharClose) cls = C_CLOSE;
    else if (c == CharPlus || c == CharMinus || c == CharMul || c == CharDiv) cls = C_OP;
    else cls = C_OTHER;
    return cls;
  endfunction

  function automatic verdict_e fail_to_verdict(input fail_e f);
    verdict_e v;
    case (f)
      F_SYNTAX:  v = V_SYNTAX;
      F_FOREIGN: v = V_FOREIGN;
      default:   v = V_PENDING;
    endcase
    return v;
  endfunction

endpackage

/* hdl/arith_expression_syntax_checker_top.sv */
// Top level of the arithmetic expression syntax checker with its output buffer.
// The checker takes one character beat per clock while the input is not stalled and
// returns one result beat for each accepted beat. The registered automaton, depth
// counter and error latch update from the accepted beat; a two-entry output buffer
// (result register plus skid register) lets a new beat in while a result waits, so
// input stall rises only when both entries are full. An end-of-line beat reports the
// line verdict and clears the line state for the next beat.
module arith_expression_syntax_checker_top import aesc_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned MAX_LEN   = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  output logic [11:0] position_o,
  output logic [7:0]  open_depth_o
);

  logic         accept;
  logic         out_free;
  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  aesc_result_t core_res;
  aesc_result_t out_res_q;
  aesc_result_t skid_res_q;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  aesc_core #(
    .MAX_DEPTH(MAX_DEPTH),
    .MAX_LEN  (MAX_LEN)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .char_code_i  (char_code_i),
    .end_of_line_i(end_of_line_i),
    .result_o     (core_res)
  );

  // Output buffer occupancy
  always_comb begin
    if (out_free) begin
      out_valid_d  = skid_valid_q || accept;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d  = 1'b1;
      skid_valid_d = skid_valid_q || accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) out_res_q <= skid_res_q;
      else if (accept) out_res_q <= core_res;
    end else if (accept) begin
      skid_res_q <= core_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = out_res_q.verdict;
  assign position_o   = out_res_q.position;
  assign open_depth_o = out_res_q.open_depth;

endmodule

/* hdl/aesc_core.sv */
// Line state of the checker: automaton, depth counter, count and latched error.
module aesc_core import aesc_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned MAX_LEN   = 4095
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   char_code_i,
  input  logic         end_of_line_i,
  output aesc_result_t result_o
);

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [DW-1:0] DepthMax = DW'(MAX_DEPTH);
  localparam logic [DW-1:0] DepthOne = DW'(1);
  localparam logic [CW-1:0] CntMax   = CW'(MAX_LEN);

  aut_state_e  state_q, state_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [CW-1:0] cnt_q, cnt_d;
  fail_e       fail_q, fail_d;
  logic [CW-1:0] fpos_q, fpos_d;

  char_class_e cls;
  aut_state_e  adv_state;
  logic        adv_ok;
  logic        depth_up;
  logic        depth_dn;
  logic        non_space;
  logic [CW-1:0] cnt_step;
  verdict_e      verdict_sel;
  logic [CW-1:0] pos_sel;
  logic [DW-1:0] depth_sel;
  logic [31:0]   pos_w;
  logic [31:0]   depth_w;

  assign cls       = classify(char_code_i);
  assign non_space = (char_code_i != CharSpace);
  assign cnt_step  = (cnt_q != CntMax) ? cnt_q + CW'(1) : cnt_q;

  // Automaton next state and depth push / pop
  always_comb begin
    adv_state = S_START;
    adv_ok    = 1'b0;
    depth_up  = 1'b0;
    depth_dn  = 1'b0;
    case (state_q)
      S_NUM_TOP: begin
        if (cls == C_NZDIGIT || cls == C_ZERO) begin
          adv_state = S_NUM_TOP;
          adv_ok    = 1'b1;
        end else if (cls == C_OP) begin
          adv_state = S_START;
          adv_ok    = 1'b1;
        end
      end
      S_OPND_PAR: begin
        if (cls == C_NZDIGIT) begin
          adv_state = S_NUM_PAR;
          adv_ok    = 1'b1;
        end else if (cls == C_OPEN && depth_q != DepthMax) begin
          adv_state = S_OPND_PAR;
          adv_ok    = 1'b1;
          depth_up  = 1'b1;
        end
      end
      S_NUM_PAR, S_CLOSE_IN: begin
        if ((cls == C_NZDIGIT || cls == C_ZERO) && state_q == S_NUM_PAR) begin
          adv_state = S_NUM_PAR;
          adv_ok    = 1'b1;
        end else if (cls == C_OP) begin
          adv_state = S_OPND_PAR;
          adv_ok    = 1'b1;
        end else if (cls == C_CLOSE && depth_q != '0) begin
          adv_state = (depth_q != DepthOne) ? S_CLOSE_IN : S_CLOSE_TOP;
          adv_ok    = 1'b1;
          depth_dn  = 1'b1;
        end
      end
      S_CLOSE_TOP: begin
        if (cls == C_OP) begin
          adv_state = S_START;
          adv_ok    = 1'b1;
        end
      end
      default: begin
        if (cls == C_NZDIGIT) begin
          adv_state = S_NUM_TOP;
          adv_ok    = 1'b1;
        end else if (cls == C_OPEN && depth_q != DepthMax) begin
          adv_state = S_OPND_PAR;
          adv_ok    = 1'b1;
          depth_up  = 1'b1;
        end
      end
    endcase
  end

  // Line state update for an accepted beat
  always_comb begin
    state_d = state_q;
    depth_d = depth_q;
    cnt_d   = cnt_q;
    fail_d  = fail_q;
    fpos_d  = fpos_q;
    if (step_i) begin
      if (end_of_line_i) begin
        state_d = S_START;
        depth_d = '0;
        cnt_d   = '0;
        fail_d  = F_NONE;
        fpos_d  = '0;
      end else if (non_space) begin
        cnt_d = cnt_step;
        if (fail_q == F_NONE) begin
          if (cls == C_OTHER) begin
            fail_d = F_FOREIGN;
            fpos_d = cnt_step;
          end else if (!adv_ok) begin
            fail_d = F_SYNTAX;
            fpos_d = cnt_step;
          end else begin
            state_d = adv_state;
            if (depth_up) depth_d = depth_q + DW'(1);
            else if (depth_dn) depth_d = depth_q - DW'(1);
          end
        end
      end
    end
  end

  // Result of the current beat
  always_comb begin
    verdict_sel = V_PENDING;
    pos_sel     = cnt_d;
    depth_sel   = depth_d;
    if (end_of_line_i) begin
      depth_sel = depth_q;
      if (fail_q != F_NONE) begin
        verdict_sel = fail_to_verdict(fail_q);
        pos_sel     = fpos_q;
      end else if (cnt_q == '0) begin
        verdict_sel = V_EMPTY;
        pos_sel     = '0;
      end else if (state_q == S_NUM_TOP || state_q == S_CLOSE_TOP) begin
        verdict_sel = V_ACCEPT;
        pos_sel     = cnt_q;
      end else begin
        verdict_sel = V_INCOMPLETE;
        pos_sel     = cnt_q;
      end
    end else if (fail_d != F_NONE) begin
      verdict_sel = fail_to_verdict(fail_d);
      pos_sel     = fpos_d;
    end
  end

  assign pos_w    = 32'(pos_sel);
  assign depth_w  = 32'(depth_sel);
  assign result_o = {verdict_sel, pos_w[11:0], depth_w[7:0]};

  // Line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_START;
      depth_q <= '0;
      cnt_q   <= '0;
      fail_q  <= F_NONE;
      fpos_q  <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      cnt_q   <= cnt_d;
      fail_q  <= fail_d;
      fpos_q  <= fpos_d;
    end
  end

endmodule

/* hdl/aesc_checker.sv */
// Port-level assertions for the expression syntax checker, bound to the top level.
module aesc_checker import aesc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  verdict_o,
  input logic [11:0] position_o,
  input logic [7:0]  open_depth_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o) &&
      $stable(position_o) && $stable(open_depth_o))
    else $error("result beat changed while stalled");

  // Input stalls only when a result is already waiting
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Only defined verdict codes leave the block
  a_verdict_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> verdict_o <= V_EMPTY)
    else $error("undefined verdict code");

  // An empty line has no characters and no open parentheses
  a_empty_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == V_EMPTY |-> position_o == 12'd0 && open_depth_o == 8'd0)
    else $error("empty line with nonzero position or depth");

  // An accepted line is balanced
  a_accept_bal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == V_ACCEPT |-> open_depth_o == 8'd0)
    else $error("accepted line with open parentheses");

endmodule

bind arith_expression_syntax_checker_top aesc_checker u_aesc_checker (.*);
